@@ design/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ design/sroc_pkg.sv @@
// ----------------------------------------------------------------------------
// sroc_pkg
// types and constants of the sensor rule output controller
// ----------------------------------------------------------------------------
package sroc_pkg;

  localparam logic [1:0] MODE_SENSOR = 2'd0;
  localparam logic [1:0] MODE_COND   = 2'd1;
  localparam logic [1:0] MODE_OVR    = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [3:0] OP_LT   = 4'd1;
  localparam logic [3:0] OP_LE   = 4'd2;
  localparam logic [3:0] OP_CLOS = 4'd3;
  localparam logic [3:0] OP_OPEN = 4'd4;
  localparam logic [3:0] OP_HALF = 4'd5;
  localparam logic [3:0] OP_OUT  = 4'd6;
  localparam logic [3:0] OP_GE   = 4'd7;
  localparam logic [3:0] OP_GT   = 4'd8;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [31:0] DEFAULT_OVR_LEN = 32'd600;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  sensor_index;
    logic [63:0] sensor_value;
    logic [2:0]  output_index;
    logic [2:0]  cond_slot;
    logic [3:0]  compare_op;
    logic [63:0] range_start;
    logic [63:0] range_len;
    logic        target_on;
    logic [63:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_output;
    logic       drive_on;
    logic       changed;
    logic       last_of_tick;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input item
    logic write_item; // apply a non-tick item
    logic tick_start; // latch tick time, clear walk counters and decision
    logic rule_read;  // issue a rule memory read
    logic rule_eval;  // evaluate the read rule
    logic emit;       // finish the output and report it
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic last_rule;
    logic last_output;
  } dp_status_t;

  // evaluate one rule against a reading
  function automatic logic rule_match(input logic [3:0] op, input logic [63:0] v,
                                      input logic [63:0] s, input logic [63:0] l);
    logic [64:0] e;
    logic        carry;
    logic        res;
    e = {1'b0, s} + {1'b0, l};
    carry = e[64];
    case (op)
      OP_LT:   res = v < s;
      OP_LE:   res = v <= s;
      OP_CLOS: res = (v >= s) && (carry || v <= e[63:0]);
      OP_OPEN: res = (v > s) && (carry || v < e[63:0]);
      OP_HALF: res = (v >= s) && (carry || v < e[63:0]);
      OP_OUT:  res = (v < s) || (!carry && v > e[63:0]);
      OP_GE:   res = !carry && v >= e[63:0];
      OP_GT:   res = !carry && v > e[63:0];
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ design/sensor_rule_output_controller_core.sv @@
// ----------------------------------------------------------------------------
// sensor_rule_output_controller_core
// rule engine driving on/off outputs from sensor readings
// ----------------------------------------------------------------------------
// Writes (sensor, condition, override) pass through dispatch and write
// states before returning to idle. A tick walks every rule slot through the
// single-port rule memory, a read and an evaluate state per slot plus an emit
// state per output. One result per output is strobed by result_valid for
// one cycle; the receiver cannot stall, results simply leave in order. No
// item is accepted while busy is high.
module sensor_rule_output_controller_core #(
  parameter int NUM_OUTPUTS      = 8,
  parameter int RULES_PER_OUTPUT = 8,
  parameter int NUM_SENSORS      = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sroc_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  output logic                 result_valid,
  output sroc_pkg::out_item_t  result
);
  import sroc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  sroc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .status(status)
  );

  // datapath
  sroc_dp #(
    .NUM_OUTPUTS(NUM_OUTPUTS), .RULES_PER_OUTPUT(RULES_PER_OUTPUT),
    .NUM_SENSORS(NUM_SENSORS)
  ) u_dp (
    .clk(clk), .rst(rst), .item(item), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .status(status), .result(result), .result_valid(result_valid)
  );
endmodule

@@ design/sroc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sroc_ctrl
// sequencer: item dispatch and the rule walk of a tick
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sroc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output sroc_pkg::dp_cmd_t     cmd,
  input  sroc_pkg::dp_status_t  status
);
  import sroc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DISP  = 6'b000010,
    S_WRITE = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_DISP;
      S_DISP:  state_next = status.is_tick ? S_READ : S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_READ:  state_next = S_EVAL;
      S_EVAL:  state_next = status.last_rule ? S_EMIT : S_READ;
      S_EMIT:  state_next = status.last_output ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // command decode
  always_comb begin
    busy           = (state != S_IDLE);
    cmd.load       = (state == S_IDLE) && start;
    cmd.write_item = (state == S_WRITE);
    cmd.tick_start = (state == S_DISP) && status.is_tick;
    cmd.rule_read  = (state == S_READ);
    cmd.rule_eval  = (state == S_EVAL);
    cmd.emit       = (state == S_EMIT);
  end

  `ASSERT_IMPLY(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_NEXT(a_read_eval, clk, rst, state == S_READ, state == S_EVAL)
  `ASSERT_NEXT(a_emit_ret, clk, rst, state == S_EMIT && status.last_output, !busy)
endmodule

@@ design/sroc_dp.sv @@
// ----------------------------------------------------------------------------
// sroc_dp
// datapath: sensor, rule and override stores, match unit, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sroc_dp #(
  parameter int NUM_OUTPUTS      = 8,
  parameter int RULES_PER_OUTPUT = 8,
  parameter int NUM_SENSORS      = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sroc_pkg::in_item_t    item,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  sroc_pkg::dp_cmd_t     cmd,
  output sroc_pkg::dp_status_t  status,
  output sroc_pkg::out_item_t   result,
  output logic                  result_valid
);
  import sroc_pkg::*;

  localparam int NR = NUM_OUTPUTS * RULES_PER_OUTPUT;
  localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int KW = (RULES_PER_OUTPUT > 1) ? $clog2(RULES_PER_OUTPUT) : 1;
  localparam int RW = (NR > 1) ? $clog2(NR) : 1;
  localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  sensor;
    logic [63:0] start;
    logic [63:0] len;
    logic        target;
  } rule_t;

  in_item_t    it;
  logic [31:0] def_len;
  logic [63:0] last_tick;
  logic [63:0] sensors [NUM_SENSORS];
  rule_t       rule_mem [NR];
  logic [NR-1:0] rule_valid;
  rule_t       rd_rule;
  logic        rd_valid;
  logic [63:0] ovr_exp [NUM_OUTPUTS];
  logic        ovr_lvl [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] st_known, st_on;
  logic [OW-1:0] o_cnt;
  logic [KW-1:0] k_cnt;
  logic        want_set, want_on;

  logic in_out_ok, in_slot_ok, in_sen_ok;
  logic [RW-1:0] wr_addr, rd_addr;
  logic [64:0] def_sum;
  logic [63:0] ovr_val;
  rule_t wr_rule, eff_rule;
  logic [63:0] rd_sensor;
  logic rd_sen_ok, hit;
  logic ovr_active, fin_set, fin_on, chg;

  // decode of the held item
  always_comb begin
    in_out_ok  = 32'(it.output_index) < NUM_OUTPUTS;
    in_slot_ok = 32'(it.cond_slot) < RULES_PER_OUTPUT;
    in_sen_ok  = 32'(it.sensor_index) < NUM_SENSORS;
    wr_addr    = RW'(32'(it.output_index) * RULES_PER_OUTPUT + 32'(it.cond_slot));
    rd_addr    = RW'(32'(o_cnt) * RULES_PER_OUTPUT + 32'(k_cnt));
    def_sum    = {1'b0, last_tick} + {33'd0, def_len};
    ovr_val    = (it.time_value != '0) ? it.time_value :
                 (def_sum[64] ? ALL_ONES : def_sum[63:0]);
    wr_rule    = '{op: it.compare_op, sensor: it.sensor_index, start: it.range_start,
                   len: it.range_len, target: it.target_on};
  end

  // config register and item capture
  always_ff @(posedge clk) begin
    if (rst) def_len <= DEFAULT_OVR_LEN;
    else if (cfg_we) def_len <= cfg_data;
    if (cmd.load) it <= item;
  end

  // rule memory, synchronous read
  always_ff @(posedge clk) begin
    if (cmd.write_item && it.mode == MODE_COND && in_out_ok && in_slot_ok)
      rule_mem[wr_addr] <= wr_rule;
    if (cmd.rule_read) rd_rule <= rule_mem[rd_addr];
  end

  // valid bits and read flag
  always_ff @(posedge clk) begin
    if (rst) rule_valid <= '0;
    else if (cmd.write_item && it.mode == MODE_COND && in_out_ok && in_slot_ok)
      rule_valid[wr_addr] <= 1'b1;
    if (cmd.rule_read) rd_valid <= rule_valid[rd_addr];
  end

  // sensors, overrides, tick time
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) sensors[i] <= ALL_ONES;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        ovr_exp[i] <= '0;
        ovr_lvl[i] <= 1'b0;
      end
      last_tick <= '0;
    end else begin
      if (cmd.write_item && it.mode == MODE_SENSOR && in_sen_ok)
        sensors[SW'(it.sensor_index)] <= it.sensor_value;
      if (cmd.write_item && it.mode == MODE_OVR && in_out_ok) begin
        ovr_exp[OW'(it.output_index)] <= ovr_val;
        ovr_lvl[OW'(it.output_index)] <= it.target_on;
      end
      if (cmd.tick_start) last_tick <= it.time_value;
    end
  end

  // match of the read rule
  always_comb begin
    eff_rule  = rd_valid ? rd_rule : '0;
    rd_sen_ok = 32'(eff_rule.sensor) < NUM_SENSORS;
    rd_sensor = rd_sen_ok ? sensors[SW'(eff_rule.sensor)] : ALL_ONES;
    hit       = rd_sen_ok && rd_sensor != ALL_ONES &&
                rule_match(eff_rule.op, rd_sensor, eff_rule.start, eff_rule.len);
    ovr_active = ovr_exp[o_cnt] > it.time_value;
    fin_set   = ovr_active || want_set;
    fin_on    = ovr_active ? ovr_lvl[o_cnt] : want_on;
    chg       = fin_set && (!st_known[o_cnt] || st_on[o_cnt] != fin_on);
  end

  // walk counters, decision and output state
  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= '0;
      k_cnt <= '0;
      want_set <= 1'b0;
      want_on <= 1'b0;
      st_known <= '0;
      st_on <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.tick_start) begin
        o_cnt <= '0;
        k_cnt <= '0;
        want_set <= 1'b0;
      end
      if (cmd.rule_eval) begin
        if (hit) begin
          want_set <= 1'b1;
          want_on <= eff_rule.target;
        end
        if (32'(k_cnt) != RULES_PER_OUTPUT - 1) k_cnt <= k_cnt + 1'b1;
      end
      if (cmd.emit) begin
        if (fin_set) begin
          st_known[o_cnt] <= 1'b1;
          st_on[o_cnt] <= fin_on;
        end
        result_valid <= 1'b1;
        result.result_output <= 3'(o_cnt);
        result.drive_on <= fin_set ? fin_on : (st_known[o_cnt] && st_on[o_cnt]);
        result.changed <= chg;
        result.last_of_tick <= (32'(o_cnt) == NUM_OUTPUTS - 1);
        k_cnt <= '0;
        want_set <= 1'b0;
        if (32'(o_cnt) != NUM_OUTPUTS - 1) o_cnt <= o_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    status.is_tick     = (it.mode == MODE_TICK);
    status.last_rule   = (32'(k_cnt) == RULES_PER_OUTPUT - 1);
    status.last_output = (32'(o_cnt) == NUM_OUTPUTS - 1);
  end

  `ASSERT_NEXT(a_emit_out, clk, rst, cmd.emit, result_valid)
  `ASSERT_IMPLY(a_chg_drive, clk, rst, result_valid && result.changed,
                result.drive_on == $past(fin_on))
  `ASSERT_IMPLY(a_no_mix, clk, rst, cmd.rule_eval, !cmd.emit && !cmd.write_item)
endmodule
